// ----- design/mncv_pkg.sv -----
// ----------------------------------------------------------------------------
// mncv_pkg
// Shared types and constants for the calibrated MIDI note to CV converter.
// ----------------------------------------------------------------------------
package mncv_pkg;

  localparam int NUM_OCTAVES     = 5;
  localparam int FULL_SCALE_CODE = 4095;
  localparam int LOWEST_NOTE     = 0;
  localparam int BEND_SEMITONES  = 2;
  localparam int BEND_CENTER     = 8192;
  localparam int SEMIS           = 12;

  localparam int NUM_NOTES = SEMIS * NUM_OCTAVES;
  localparam int TOP_NOTE  = LOWEST_NOTE + NUM_NOTES;
  localparam int VPO       = FULL_SCALE_CODE / NUM_OCTAVES;
  localparam int BEND_MAX  = (FULL_SCALE_CODE / NUM_NOTES) * BEND_SEMITONES;
  localparam int BEND_SH   = $clog2(BEND_CENTER);

  // field widths
  localparam int CH_W    = 4;
  localparam int NOTE_W  = 7;
  localparam int BEND_W  = 14;
  localparam int CODE_W  = 12;
  localparam int CAL_W   = 10;
  localparam int NUM_CAL = 7;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_LISTEN_CHANNEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET_0   = 3'd1;

  // octave index: rel / 12 as (rel * 43) >> 9, exact for rel <= 60
  localparam int REL_W        = $clog2(NUM_NOTES + 1);
  localparam int OCT_W        = $clog2(NUM_CAL);
  localparam int OCT_RECIP    = 43;
  localparam int OCT_RECIP_W  = 6;
  localparam int OCT_RECIP_SH = 9;
  localparam int OCTP_W       = REL_W + OCT_RECIP_W;

  // linear map: rel * 4095 / 60 as (rel * 273) >> 2, exact since 4 * 4095 = 273 * 60
  localparam int RAW_SH  = 2;
  localparam int RAW_MUL = (FULL_SCALE_CODE << RAW_SH) / NUM_NOTES;

  // octave span division: p / 819 as (p * ceil(2^30 / 819)) >> 30,
  // exact for the calibration products, which stay below 2^21
  localparam int VPO_RECIP_SH = 30;
  localparam int VPO_RECIP    = ((1 << VPO_RECIP_SH) + VPO - 1) / VPO;

  // shared multiplier
  localparam int MUL_A_W = 21;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SPAN_W  = 14;
  localparam int QMAG_W  = 12;
  localparam int NSUM_W  = 18;
  localparam int BTERM_W = 13;
  localparam int SUM_W   = 17;

  typedef struct packed {
    logic [CH_W-1:0]   msg_channel;
    logic              note_on;
    logic [NOTE_W-1:0] note_number;
    logic              bend_from_midi;
    logic [BEND_W-1:0] midi_bend;
    logic [BEND_W-1:0] panel_bend;
  } msg_t;

  typedef struct packed {
    logic [CODE_W-1:0] dac_code;
    logic              dac_write;
    logic              gate;
  } cv_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_RAW,
    S_MUL_CAL,
    S_MUL_RECIP,
    S_NOTE,
    S_MUL_BEND,
    S_SUM
  } state_t;

endpackage

// ----- design/midi_note_to_cv_calibrated_core.sv -----
// ----------------------------------------------------------------------------
// midi_note_to_cv_calibrated_core
// Calibrated volt-per-octave note to DAC code converter with pitch bend.
// ----------------------------------------------------------------------------
// One beat in, at most one beat out. A beat on a channel other than the
// listen channel is taken and dropped, and the input stays open. A beat with
// note_on set reaches the output register through the linear map, the
// calibration product, the reciprocal multiply for the octave division, the
// held-code update, the bend product and the sum, with every product on the
// one shared 21 by 21 multiplier. A beat without note_on has only the bend
// product and sum. The input reopens as the result is registered, so a new
// beat is taken only once the last one is through. msg_stall is high while a beat
// is in work or its result waits for the output register. Configuration
// writes take effect at once.
// ----------------------------------------------------------------------------
module midi_note_to_cv_calibrated_core
  import mncv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  msg_valid,
  output logic                  msg_stall,
  input  msg_t                  msg,
  output logic                  cv_valid,
  input  logic                  cv_stall,
  output cv_t                   cv
);

  state_t state, state_next;

  logic [CH_W-1:0]         listen_channel;
  logic signed [CAL_W-1:0] cal_offset [NUM_CAL];

  msg_t                    msg_q;
  logic signed [CAL_W-1:0] c0, c0_next, c1, c1_next;
  logic [PROD_W-1:0]       quo, quo_next;
  logic                    neg, neg_next;
  logic [CODE_W-1:0]       held_note_code, held_note_code_next;
  logic [CODE_W-1:0]       last_written_code, last_written_code_next;
  cv_t                     cv_q, cv_q_next;
  logic                    cv_valid_next;

  logic                    msg_take, out_free;
  logic [NOTE_W-1:0]       note_cl;
  logic [REL_W-1:0]        rel;
  logic [OCTP_W-1:0]       oct_prod;
  logic [OCT_W-1:0]        k, k1;
  logic [CODE_W-1:0]       lo, raw;
  logic signed [SPAN_W-1:0] span;
  logic [SPAN_W-1:0]       span_mag;
  logic [BEND_W-1:0]       bend_raw, bend_mag;
  logic                    bend_neg;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [PROD_W-1:0]       mul_p;
  logic signed [NSUM_W-1:0] q_s, note_sum;
  logic [CODE_W-1:0]       note_sat;
  logic signed [SUM_W-1:0] bend_s, sum;
  logic [CODE_W-1:0]       code;

  assign msg_stall = (state != S_IDLE);
  assign msg_take  = msg_valid && !msg_stall;
  assign out_free  = !cv_valid || !cv_stall;
  assign cv        = cv_q;

  // note clamp and octave
  always_comb begin
    if (msg_q.note_number < NOTE_W'(LOWEST_NOTE)) begin
      note_cl = NOTE_W'(LOWEST_NOTE);
    end else if (msg_q.note_number > NOTE_W'(TOP_NOTE)) begin
      note_cl = NOTE_W'(TOP_NOTE);
    end else begin
      note_cl = msg_q.note_number;
    end
  end

  assign rel      = REL_W'(note_cl - NOTE_W'(LOWEST_NOTE));
  assign oct_prod = OCTP_W'(rel) * OCTP_W'(OCT_RECIP);
  assign k        = oct_prod[OCT_RECIP_SH +: OCT_W];
  assign k1       = OCT_W'(k + OCT_W'(1));
  assign lo       = CODE_W'(VPO * k);
  assign raw      = quo[RAW_SH +: CODE_W];

  assign span     = SPAN_W'(VPO) + SPAN_W'(c1) - SPAN_W'(c0);
  assign span_mag = span[SPAN_W-1] ? SPAN_W'(-span) : SPAN_W'(span);

  assign bend_raw = msg_q.bend_from_midi ? msg_q.midi_bend : msg_q.panel_bend;
  assign bend_neg = bend_raw < BEND_W'(BEND_CENTER);
  assign bend_mag = bend_neg ? BEND_W'(BEND_W'(BEND_CENTER) - bend_raw)
                             : BEND_W'(bend_raw - BEND_W'(BEND_CENTER));

  // shared multiplier
  always_comb begin
    case (state)
      S_MUL_RAW: begin
        mul_a = MUL_A_W'(rel);
        mul_b = MUL_B_W'(RAW_MUL);
      end
      S_MUL_CAL: begin
        mul_a = MUL_A_W'(CODE_W'(raw - lo));
        mul_b = MUL_B_W'(span_mag);
      end
      S_MUL_RECIP: begin
        mul_a = quo[MUL_A_W-1:0];
        mul_b = MUL_B_W'(VPO_RECIP);
      end
      S_MUL_BEND: begin
        mul_a = MUL_A_W'(bend_mag);
        mul_b = MUL_B_W'(BEND_MAX);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // calibrated note code
  always_comb begin
    q_s = NSUM_W'($signed({1'b0, quo[VPO_RECIP_SH +: QMAG_W]}));
    if (neg) begin
      q_s = -q_s;
    end
    note_sum = q_s + NSUM_W'($signed({1'b0, lo})) + NSUM_W'(c0);
    if (note_sum < 0) begin
      note_sat = '0;
    end else if (note_sum > NSUM_W'(FULL_SCALE_CODE)) begin
      note_sat = CODE_W'(FULL_SCALE_CODE);
    end else begin
      note_sat = note_sum[CODE_W-1:0];
    end
  end

  // bend sum
  always_comb begin
    bend_s = SUM_W'($signed({1'b0, quo[BEND_SH +: BTERM_W]}));
    if (neg) begin
      bend_s = -bend_s;
    end
    sum = SUM_W'($signed({1'b0, held_note_code})) + bend_s;
    if (sum < 0) begin
      code = '0;
    end else if (sum > SUM_W'(FULL_SCALE_CODE)) begin
      code = CODE_W'(FULL_SCALE_CODE);
    end else begin
      code = sum[CODE_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (msg_take && msg.msg_channel == listen_channel) begin
          state_next = msg.note_on ? S_MUL_RAW : S_MUL_BEND;
        end
      end
      S_MUL_RAW:   state_next = S_MUL_CAL;
      S_MUL_CAL:   state_next = S_MUL_RECIP;
      S_MUL_RECIP: state_next = S_NOTE;
      S_NOTE:      state_next = S_MUL_BEND;
      S_MUL_BEND:  state_next = S_SUM;
      S_SUM: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    quo_next               = quo;
    neg_next               = neg;
    c0_next                = c0;
    c1_next                = c1;
    held_note_code_next    = held_note_code;
    last_written_code_next = last_written_code;
    cv_q_next              = cv_q;
    cv_valid_next          = cv_valid && cv_stall;
    unique case (state)
      S_MUL_RAW: begin
        quo_next = mul_p;
        c0_next  = cal_offset[k];
        c1_next  = cal_offset[k1];
      end
      S_MUL_CAL: begin
        quo_next = mul_p;
        neg_next = span[SPAN_W-1];
      end
      S_MUL_RECIP: begin
        quo_next = mul_p;
      end
      S_NOTE: begin
        held_note_code_next = note_sat;
      end
      S_MUL_BEND: begin
        quo_next = mul_p;
        neg_next = bend_neg;
      end
      S_SUM: begin
        if (out_free) begin
          cv_q_next.dac_code  = code;
          cv_q_next.dac_write = (code != last_written_code);
          cv_q_next.gate      = msg_q.note_on;
          cv_valid_next       = 1'b1;
          last_written_code_next = code;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      cv_valid          <= 1'b0;
      held_note_code    <= '0;
      last_written_code <= '0;
      listen_channel    <= '0;
      for (int i = 0; i < NUM_CAL; i++) begin
        cal_offset[i] <= '0;
      end
    end else begin
      state             <= state_next;
      cv_valid          <= cv_valid_next;
      held_note_code    <= held_note_code_next;
      last_written_code <= last_written_code_next;
      if (cfg_write) begin
        if (cfg_index == REG_LISTEN_CHANNEL) begin
          listen_channel <= cfg_data[CH_W-1:0];
        end else begin
          cal_offset[OCT_W'(cfg_index - REG_CAL_OFFSET_0)] <= cfg_data[CAL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg_take) begin
      msg_q <= msg;
    end
    quo  <= quo_next;
    neg  <= neg_next;
    c0   <= c0_next;
    c1   <= c1_next;
    cv_q <= cv_q_next;
  end

endmodule

// ----- tb/midi_note_to_cv_calibrated_core_tb.sv -----
// ----------------------------------------------------------------------------
// midi_note_to_cv_calibrated_core_tb
// Self-checking bench for the calibrated note to CV converter. An in-bench
// model of the note map, the per-octave calibration, the bend and the write
// flag predicts every cv beat. Directed corner cases come first, then random
// MIDI states under several channel and calibration settings, random idle
// and stall patterns on both sides, and a long output hold that backs the
// block up.
// ----------------------------------------------------------------------------
module midi_note_to_cv_calibrated_core_tb;
  import mncv_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE       = 80;
  localparam int LONG_HOLD    = 250;
  localparam int MAX_CYCLES   = 1000000;
  localparam int REPORT_LIMIT = 10;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  msg_valid = 1'b0;
  logic                  msg_stall;
  msg_t                  msg       = '0;
  logic                  cv_valid;
  logic                  cv_stall  = 1'b0;
  cv_t                   cv;

  // model state
  logic [CH_W-1:0]   model_channel = '0;
  int                model_cal [NUM_CAL];
  logic [CODE_W-1:0] held_code = '0;
  logic [CODE_W-1:0] last_code = '0;

  cv_t pending_cv_q [$];
  int  fail_count   = 0;
  int  send_gap_pct = 0;
  int  stall_pct    = 0;
  logic long_hold   = 1'b0;

  midi_note_to_cv_calibrated_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .cv_valid  (cv_valid),
    .cv_stall  (cv_stall),
    .cv        (cv)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(MAX_CYCLES * CLK_PERIOD);
    $display("FAIL");
    $finish;
  end

  function automatic int clamp_code(input int v);
    if (v < 0) return 0;
    if (v > FULL_SCALE_CODE) return FULL_SCALE_CODE;
    return v;
  endfunction

  function automatic int calibrated_code(input logic [NOTE_W-1:0] note);
    int n, oct, base, lin, span;
    n = int'(note);
    if (n < LOWEST_NOTE) n = LOWEST_NOTE;
    if (n > TOP_NOTE) n = TOP_NOTE;
    n = n - LOWEST_NOTE;
    oct = n / SEMIS;
    base = VPO * oct;
    lin = n * FULL_SCALE_CODE / NUM_NOTES;
    span = VPO + model_cal[oct + 1] - model_cal[oct];
    return clamp_code((lin - base) * span / VPO + base + model_cal[oct]);
  endfunction

  function automatic int bend_offset(input logic [BEND_W-1:0] b);
    return (int'(b) - BEND_CENTER) * BEND_MAX / BEND_CENTER;
  endfunction

  function automatic void predict_cv(input msg_t m);
    cv_t r;
    int sum;
    logic [BEND_W-1:0] b;
    if (m.msg_channel != model_channel) return;
    if (m.note_on) held_code = CODE_W'(calibrated_code(m.note_number));
    b = m.bend_from_midi ? m.midi_bend : m.panel_bend;
    sum = clamp_code(int'(held_code) + bend_offset(b));
    r.dac_code = CODE_W'(sum);
    r.dac_write = (r.dac_code != last_code);
    if (r.dac_write) last_code = r.dac_code;
    r.gate = m.note_on;
    pending_cv_q.push_back(r);
  endfunction

  function automatic msg_t mk_msg(input int ch, input bit on, input int note,
                                  input bit from_midi, input int mb, input int pb);
    msg_t m;
    m.msg_channel = CH_W'(ch);
    m.note_on = on;
    m.note_number = NOTE_W'(note);
    m.bend_from_midi = from_midi;
    m.midi_bend = BEND_W'(mb);
    m.panel_bend = BEND_W'(pb);
    return m;
  endfunction

  function automatic int pick_bend();
    int r;
    r = $urandom_range(9);
    if (r < 3) return BEND_CENTER;
    if (r == 3) return 0;
    if (r == 4) return (1 << BEND_W) - 1;
    return $urandom_range((1 << BEND_W) - 1);
  endfunction

  function automatic msg_t random_msg();
    msg_t m;
    m.msg_channel = ($urandom_range(99) < 85) ? model_channel : CH_W'($urandom);
    m.note_on = 1'($urandom_range(1));
    m.note_number = ($urandom_range(99) < 70) ? NOTE_W'($urandom_range(TOP_NOTE))
                                              : NOTE_W'($urandom);
    m.bend_from_midi = 1'($urandom_range(1));
    m.midi_bend = BEND_W'(pick_bend());
    m.panel_bend = BEND_W'(pick_bend());
    return m;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    if (idx == REG_LISTEN_CHANNEL)
      model_channel = CH_W'(val);
    else
      model_cal[int'(idx) - int'(REG_CAL_OFFSET_0)] = int'($signed(CAL_W'(val)));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_cal(input int lo, input int hi);
    for (int i = 0; i < NUM_CAL; i++)
      write_reg(CFG_IDX_W'(int'(REG_CAL_OFFSET_0) + i), lo + $urandom_range(hi - lo));
  endtask

  // beat stays valid after acceptance until the next send or wait_idle
  task automatic send_msg(input msg_t m);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg <= m;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    predict_cv(m);
  endtask

  task automatic wait_idle();
    msg_valid <= 1'b0;
    while (pending_cv_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    msg_t m;
    int n;
    n = 0;
    while (n < count) begin
      m = random_msg();
      send_msg(m);
      if (m.msg_channel == model_channel) n++;
    end
  endtask

  task automatic test_reset_defaults();
    send_msg(mk_msg(0, 1, 0, 1, BEND_CENTER, 0));
    send_msg(mk_msg(0, 1, 60, 1, BEND_CENTER, 0));
    send_msg(mk_msg(0, 1, 127, 0, 0, BEND_CENTER));
    send_msg(mk_msg(0, 0, 5, 1, 16383, 0));
    send_msg(mk_msg(0, 0, 5, 0, 16383, 0));
    send_msg(mk_msg(0, 1, 0, 0, BEND_CENTER, 0));
    send_msg(mk_msg(9, 1, 30, 1, 0, 0));
    send_msg(mk_msg(15, 1, 127, 0, 16383, 16383));
    send_msg(mk_msg(0, 1, 61, 1, 'h2AAA, 'h1555));
    send_msg(mk_msg(0, 1, 35, 0, 'h1555, 'h2AAA));
    send_msg(mk_msg(0, 0, 35, 0, 'h1555, 'h2AAA));
    send_msg(mk_msg(0, 1, 12, 1, 16383, 0));
    wait_idle();
  endtask

  task automatic test_calibration_extremes();
    int notes [6];
    notes = '{0, 11, 24, 47, 60, 127};
    write_reg(REG_LISTEN_CHANNEL, 15);
    program_cal(511, 511);
    foreach (notes[i]) send_msg(mk_msg(15, 1, notes[i], 1, BEND_CENTER, 0));
    wait_idle();
    program_cal(-512, -512);
    foreach (notes[i]) send_msg(mk_msg(15, 1, notes[i], 0, 0, BEND_CENTER));
    wait_idle();
  endtask

  task automatic test_random_phase(input int gap, input int stall, input int cal_span,
                                   input int count);
    write_reg(REG_LISTEN_CHANNEL, $urandom_range(15));
    program_cal(-cal_span, cal_span);
    send_gap_pct = gap;
    stall_pct = stall;
    send_random(count);
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    stall_pct = 0;
    fork
      begin
        long_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold <= 1'b0;
      end
      send_random(30);
    join
    wait_idle();
  endtask

  always @(posedge clk) begin
    cv_stall <= long_hold || (stall_pct != 0 && $urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cv_t exp;
    if (!rst && cv_valid && !cv_stall) begin
      if (pending_cv_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected cv beat: code %0d write %0b gate %0b",
                   cv.dac_code, cv.dac_write, cv.gate);
      end else begin
        exp = pending_cv_q.pop_front();
        if (cv.dac_code !== exp.dac_code || cv.dac_write !== exp.dac_write ||
            cv.gate !== exp.gate) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display({"cv mismatch: expected code %0d write %0b gate %0b, ",
                      "got code %0d write %0b gate %0b"},
                     exp.dac_code, exp.dac_write, exp.gate,
                     cv.dac_code, cv.dac_write, cv.gate);
        end
      end
    end
  end

  initial begin
    foreach (model_cal[i]) model_cal[i] = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_calibration_extremes();
    test_random_phase(0, 0, 40, 150);
    test_random_phase(85, 0, 512, 150);
    test_random_phase(0, 85, 40, 150);
    test_random_phase(38, 38, 200, 150);
    test_backpressure();
    fail_count += pending_cv_q.size();
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- midi_note_to_cv_calibrated_core.f -----
design/mncv_pkg.sv
design/midi_note_to_cv_calibrated_core.sv
tb/midi_note_to_cv_calibrated_core_tb.sv
